// File: sv/ggc_pkg.sv
// ----------------------------------------------------------------------------
// ggc_pkg: shared types and constants for the greedy graph coloring core
// Sizes of the node table, the color space and the neighbor lanes.
// ----------------------------------------------------------------------------
package ggc_pkg;

	localparam int MAX_NODES = 64;
	localparam int NODE_W    = 6;
	localparam int COLOR_W   = 6;
	localparam int COUNT_W   = 7;

	// Each lane checks LANE_W earlier nodes; MAX_NODES is a multiple of LANE_W.
	localparam int LANE_W    = 8;
	localparam int LANES     = MAX_NODES / LANE_W;

	typedef logic [NODE_W-1:0]               node_t;
	typedef logic [COLOR_W-1:0]              color_t;
	typedef logic [COUNT_W-1:0]              count_t;
	typedef logic [MAX_NODES-1:0]            row_t;
	typedef logic [MAX_NODES-1:0]            mask_t;
	typedef logic [LANE_W-1:0]               lane_row_t;
	typedef color_t [LANE_W-1:0]             lane_colors_t;
	typedef mask_t [LANES-1:0]               lane_masks_t;
	typedef color_t [MAX_NODES-1:0]          color_table_t;

endpackage

// File: sv/ggc_if.sv
// ----------------------------------------------------------------------------
// ggc interfaces: valid/ready channels of the greedy graph coloring core
// Input rows, colored results and the node count write channel.
// ----------------------------------------------------------------------------
interface ggc_item_if
	import ggc_pkg::*;
();
	logic valid;
	logic ready;
	row_t neighbours;
	logic restart;

	modport source (output valid, output neighbours, output restart, input ready);
	modport sink (input valid, input neighbours, input restart, output ready);
endinterface

interface ggc_result_if
	import ggc_pkg::*;
();
	logic   valid;
	logic   ready;
	node_t  node_number;
	color_t color;
	logic   last;

	modport source (output valid, output node_number, output color, output last,
		input ready);
	modport sink (input valid, input node_number, input color, input last,
		output ready);
endinterface

interface ggc_cfg_if
	import ggc_pkg::*;
();
	logic   valid;
	logic   ready;
	count_t node_count;

	modport source (output valid, output node_count, input ready);
	modport sink (input valid, input node_count, output ready);
endinterface

// File: sv/ggc_lane.sv
// ----------------------------------------------------------------------------
// ggc_lane: one neighbor lane
// Collects the colors held by the set neighbors of its slice of nodes into a
// registered used-color mask.
// ----------------------------------------------------------------------------
module ggc_lane
	import ggc_pkg::*;
(
	input  logic         clk,
	input  logic         en,
	input  lane_row_t    rows,
	input  lane_colors_t colors,
	output mask_t        used_s2
);

	mask_t used;

	always_comb begin
		used = '0;
		for (int i = 0; i < LANE_W; i++) begin
			if (rows[i]) begin
				used = used | (mask_t'(1) << colors[i]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			used_s2 <= used;
		end
	end

endmodule

// File: sv/ggc_merge.sv
// ----------------------------------------------------------------------------
// ggc_merge: lane merge and first-fit color pick
// ORs the lane masks and picks the lowest color that is not in use.
// ----------------------------------------------------------------------------
module ggc_merge
	import ggc_pkg::*;
(
	input  lane_masks_t masks,
	output color_t      color
);

	mask_t used;

	always_comb begin
		used = '0;
		for (int l = 0; l < LANES; l++) begin
			used = used | masks[l];
		end
	end

	// The top color is taken when every lower one is in use.
	always_comb begin
		color = color_t'(MAX_NODES - 1);
		for (int c = MAX_NODES - 2; c >= 0; c--) begin
			if (!used[c]) begin
				color = color_t'(c);
			end
		end
	end

endmodule

// File: sv/greedy_graph_coloring_core.sv
// ----------------------------------------------------------------------------
// greedy_graph_coloring_core: first-fit coloring of one node per transfer
// A result passes the input, lane and output registers. A new node is taken
// only when idle or as the merge stage finishes, as the lane and merge stages
// share one item at a time; a stalled result holds the merge stage.
// Reset clears the node numbering, the node count (to 64) and the output valid;
// the color table is not cleared.
// ----------------------------------------------------------------------------
module greedy_graph_coloring_core
	import ggc_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	ggc_item_if.sink            items,
	ggc_result_if.source        results,
	ggc_cfg_if.sink             cfg
);

	typedef enum logic [1:0] {ST_IDLE, ST_LANE, ST_MERGE} state_t;

	state_t       state_q;
	count_t       count_q;
	node_t        next_node_q;
	logic         out_valid_q;
	node_t        out_node_q;
	color_t       out_color_q;
	logic         out_last_q;

	node_t        node_s1;
	row_t         rows_s1;
	logic         last_s1;

	color_table_t colors_q;
	lane_masks_t  masks_s2;
	color_t       color;

	logic         advance;
	logic         take;
	node_t        next_after;
	node_t        base_node;
	count_t       eff_count;
	node_t        node_pick;
	logic         last_pick;
	row_t         rows_pick;

	assign cfg.ready = 1'b1;

	assign advance = (state_q == ST_MERGE) && (!out_valid_q || results.ready);
	assign items.ready = (state_q == ST_IDLE) || advance;
	assign take = items.valid && items.ready;

	assign next_after = last_s1 ? '0 : node_t'(node_s1 + 1'b1);
	// A transfer taken while the merge stage finishes uses the number it leaves.
	assign base_node = (state_q == ST_MERGE) ? next_after : next_node_q;

	always_comb begin
		if (count_q == '0) begin
			eff_count = count_t'(1);
		end else if (count_q > count_t'(MAX_NODES)) begin
			eff_count = count_t'(MAX_NODES);
		end else begin
			eff_count = count_q;
		end

		node_pick = items.restart ? '0 : base_node;
		if ({1'b0, node_pick} >= eff_count) begin
			node_pick = '0;
		end
		last_pick = ({1'b0, node_pick} == count_t'(eff_count - 1'b1));
		rows_pick = items.neighbours & ~({MAX_NODES{1'b1}} << node_pick);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= count_t'(MAX_NODES);
			next_node_q <= '0;
			out_valid_q <= 1'b0;
			out_node_q  <= '0;
			out_color_q <= '0;
			out_last_q  <= 1'b0;
		end else begin
			if (cfg.valid) begin
				count_q <= cfg.node_count;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
				out_node_q  <= node_s1;
				out_color_q <= color;
				out_last_q  <= last_s1;
				next_node_q <= next_after;
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (take) begin
						state_q <= ST_LANE;
					end
				end
				ST_LANE: begin
					state_q <= ST_MERGE;
				end
				ST_MERGE: begin
					if (advance) begin
						state_q <= take ? ST_LANE : ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			node_s1 <= node_pick;
			rows_s1 <= rows_pick;
			last_s1 <= last_pick;
		end
		if (advance) begin
			colors_q[node_s1] <= color;
		end
	end

	for (genvar l = 0; l < LANES; l++) begin : g_lane
		ggc_lane u_lane (
			.clk     (clk),
			.en      (state_q == ST_LANE),
			.rows    (rows_s1[l*LANE_W +: LANE_W]),
			.colors  (colors_q[l*LANE_W +: LANE_W]),
			.used_s2 (masks_s2[l])
		);
	end

	ggc_merge u_merge (
		.masks (masks_s2),
		.color (color)
	);

	assign results.valid       = out_valid_q;
	assign results.node_number = out_node_q;
	assign results.color       = out_color_q;
	assign results.last        = out_last_q;

endmodule

// File: sv/ggc_checker.sv
// ----------------------------------------------------------------------------
// ggc_checker: port-level checks for the greedy graph coloring core
// Watches the channels of the top level and is bound to it below.
// ----------------------------------------------------------------------------
module ggc_checker
	import ggc_pkg::*;
(
	input logic   clk,
	input logic   arst_n,
	input logic   in_valid,
	input logic   in_ready,
	input logic   out_valid,
	input logic   out_ready,
	input node_t  out_node,
	input color_t out_color
);

	// A waiting result keeps its contents until it is taken.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_node) && $stable(out_color))
		else $error("result changed while stalled");

	// After an input transfer the lanes are busy, so the input is not ready in the next cycle.
	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken while lanes busy");

	// A node has at most node_number earlier neighbors, so first fit stays at or below it.
	a_color_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_color <= out_node)
		else $error("color exceeds node number");

endmodule

bind greedy_graph_coloring_core ggc_checker u_ggc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (items.valid),
	.in_ready  (items.ready),
	.out_valid (results.valid),
	.out_ready (results.ready),
	.out_node  (results.node_number),
	.out_color (results.color)
);

// File: sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for greedy_graph_coloring_core
// A table of directed rows and count writes runs first. Random graphs follow,
// from well-formed graphs to cut-short, wrapped and restarted ones. Every result
// is checked against its typed table entry or an in-bench first-fit coloring predictor.
// ----------------------------------------------------------------------------
module testbench;
	import ggc_pkg::*;

	localparam int   IDLE_LIMIT   = 2000;
	localparam int   HOLD_CYCLES  = 300;
	localparam int   RANDOM_ITEMS = 600;
	localparam row_t ALL_ONES     = {MAX_NODES{1'b1}};

	typedef enum logic {PLAN_ITEM, PLAN_COUNT} plan_kind_t;
	typedef enum logic [1:0] {ROWS_SPARSE, ROWS_EVEN, ROWS_DENSE, ROWS_FULL} density_t;

	typedef struct packed {
		node_t  node;
		color_t color;
		logic   last;
	} coloring_t;

	typedef struct {
		plan_kind_t kind;
		row_t       data;
		logic       restart;
		logic       typed;
		coloring_t  want;
	} plan_row_t;

	logic clk;
	logic arst_n;

	ggc_item_if   item_ch ();
	ggc_result_if result_ch ();
	ggc_cfg_if    count_ch ();

	greedy_graph_coloring_core u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.items   (item_ch),
		.results (result_ch),
		.cfg     (count_ch)
	);

	// Shadow state of the coloring.
	color_t    shadow_colors [MAX_NODES];
	node_t     shadow_next;
	count_t    shadow_count;
	coloring_t pending_colorings [$];

	int failures     = 0;
	bit calm         = 1'b0;
	bit hold_request = 1'b0;

	// Directed part: typed expectations where they are obvious from the rules.
	plan_row_t plan [23] = '{
		// Node 0 ignores every neighbor bit.
		'{PLAN_ITEM,  ALL_ONES,               1'b0, 1'b1, '{6'd0, 6'd0, 1'b0}},
		'{PLAN_ITEM,  64'h1,                  1'b0, 1'b1, '{6'd1, 6'd1, 1'b0}},
		'{PLAN_ITEM,  ALL_ONES,               1'b0, 1'b1, '{6'd2, 6'd2, 1'b0}},
		'{PLAN_ITEM,  64'h0,                  1'b0, 1'b1, '{6'd3, 6'd0, 1'b0}},
		'{PLAN_ITEM,  64'hA,                  1'b0, 1'b0, '{6'd0, 6'd0, 1'b0}},
		'{PLAN_ITEM,  ALL_ONES,               1'b1, 1'b1, '{6'd0, 6'd0, 1'b0}},
		// A one-node graph: every item is the last one.
		'{PLAN_COUNT, 64'd1,                  1'b0, 1'b0, '{6'd0, 6'd0, 1'b0}},
		'{PLAN_ITEM,  ALL_ONES,               1'b0, 1'b1, '{6'd0, 6'd0, 1'b1}},
		'{PLAN_ITEM,  ALL_ONES,               1'b0, 1'b1, '{6'd0, 6'd0, 1'b1}},
		// A count of zero acts as one.
		'{PLAN_COUNT, 64'd0,                  1'b0, 1'b0, '{6'd0, 6'd0, 1'b0}},
		'{PLAN_ITEM,  64'h8000_0000_0000_0000, 1'b0, 1'b1, '{6'd0, 6'd0, 1'b1}},
		'{PLAN_COUNT, 64'd2,                  1'b0, 1'b0, '{6'd0, 6'd0, 1'b0}},
		'{PLAN_ITEM,  64'h0,                  1'b0, 1'b1, '{6'd0, 6'd0, 1'b0}},
		'{PLAN_ITEM,  64'h1,                  1'b0, 1'b1, '{6'd1, 6'd1, 1'b1}},
		'{PLAN_ITEM,  ALL_ONES,               1'b0, 1'b1, '{6'd0, 6'd0, 1'b0}},
		// A count above the table size acts as the table size.
		'{PLAN_COUNT, 64'd127,                1'b0, 1'b0, '{6'd0, 6'd0, 1'b0}},
		'{PLAN_ITEM,  64'h1,                  1'b0, 1'b1, '{6'd1, 6'd1, 1'b0}},
		'{PLAN_ITEM,  64'h2,                  1'b0, 1'b0, '{6'd0, 6'd0, 1'b0}},
		'{PLAN_ITEM,  64'h5555_5555_5555_5555, 1'b0, 1'b0, '{6'd0, 6'd0, 1'b0}},
		// Lowering the count below the next node starts a new graph.
		'{PLAN_COUNT, 64'd2,                  1'b0, 1'b0, '{6'd0, 6'd0, 1'b0}},
		'{PLAN_ITEM,  ALL_ONES,               1'b0, 1'b1, '{6'd0, 6'd0, 1'b0}},
		'{PLAN_ITEM,  64'hFFFF_FFFF_FFFF_FFFE, 1'b1, 1'b1, '{6'd0, 6'd0, 1'b0}},
		'{PLAN_COUNT, 64'd64,                 1'b0, 1'b0, '{6'd0, 6'd0, 1'b0}}
	};

	initial begin
		clk = 1'b0;
	end

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic int effective_nodes(count_t value);
		if (value == 0)
			return 1;
		if (value > MAX_NODES)
			return MAX_NODES;
		return int'(value);
	endfunction

	function automatic coloring_t first_fit_color(row_t neighbours, logic restart);
		int        limit;
		int        node;
		int        q;
		mask_t     taken;
		coloring_t res;
		limit = effective_nodes(shadow_count);
		node = restart ? 0 : int'(shadow_next);
		if (node >= limit)
			node = 0;
		taken = '0;
		for (q = 0; q < node; q++) begin
			if (neighbours[q])
				taken[shadow_colors[q]] = 1'b1;
		end
		res.color = '0;
		while (res.color < MAX_NODES - 1 && taken[res.color])
			res.color++;
		shadow_colors[node] = res.color;
		res.node = node_t'(node);
		res.last = (node == limit - 1);
		shadow_next = res.last ? '0 : node_t'(node + 1);
		return res;
	endfunction

	function automatic row_t random_row(density_t density);
		case (density)
			ROWS_SPARSE: return {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
			ROWS_EVEN:   return {$urandom, $urandom};
			ROWS_DENSE:  return {$urandom, $urandom} | {$urandom, $urandom};
			default:     return ALL_ONES;
		endcase
	endfunction

	task automatic report_mismatch(string what);
		failures++;
		$display("mismatch at %0t: %s", $time, what);
	endtask

	// Offers one row; the expectation is recorded at the transfer.
	task automatic push_row(row_t neighbours, logic restart, logic typed, coloring_t want);
		coloring_t predicted;
		while (!calm && $urandom_range(99) < 14) begin
			item_ch.valid <= 1'b0;
			@(posedge clk);
		end
		item_ch.valid      <= 1'b1;
		item_ch.neighbours <= neighbours;
		item_ch.restart    <= restart;
		do @(posedge clk); while (!item_ch.ready);
		predicted = first_fit_color(neighbours, restart);
		pending_colorings.push_back(typed ? want : predicted);
	endtask

	task automatic drain_results();
		item_ch.valid <= 1'b0;
		while (pending_colorings.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_node_count(count_t value);
		count_ch.valid      <= 1'b1;
		count_ch.node_count <= value;
		do @(posedge clk); while (!count_ch.ready);
		count_ch.valid <= 1'b0;
		shadow_count = value;
	endtask

	// Stimulus
	initial begin
		int       phase;
		int       sent;
		int       nodes;
		int       span;
		int       pick;
		int       k;
		count_t   count_value;
		density_t density;
		arst_n              = 1'b0;
		item_ch.valid       = 1'b0;
		item_ch.neighbours  = '0;
		item_ch.restart     = 1'b0;
		count_ch.valid      = 1'b0;
		count_ch.node_count = '0;
		foreach (shadow_colors[i])
			shadow_colors[i] = '0;
		shadow_next  = '0;
		shadow_count = count_t'(MAX_NODES);
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i]) begin
			if (plan[i].kind == PLAN_COUNT) begin
				drain_results();
				write_node_count(count_t'(plan[i].data));
			end else begin
				push_row(plan[i].data, plan[i].restart, plan[i].typed, plan[i].want);
			end
		end

		sent = 0;
		phase = 0;
		while (sent < RANDOM_ITEMS) begin
			pick = $urandom_range(99);
			if (phase == 0 || pick < 4)
				count_value = count_t'(MAX_NODES);
			else if (pick < 10)
				count_value = count_t'($urandom_range(13, MAX_NODES - 1));
			else if (pick < 13)
				count_value = $urandom_range(1) ? count_t'(0) : count_t'(127);
			else if (pick < 17)
				count_value = count_t'(1);
			else
				count_value = count_t'($urandom_range(2, 12));
			drain_results();
			write_node_count(count_value);
			nodes = effective_nodes(count_value);

			// Mostly whole graphs; some stop early, some run on into the next graph.
			pick = $urandom_range(99);
			if (phase == 0 || pick >= 25)
				span = nodes;
			else if (pick < 15)
				span = $urandom_range(1, nodes);
			else
				span = nodes + $urandom_range(1, nodes);
			density = (phase == 0) ? ROWS_FULL : density_t'($urandom_range(3));
			if (phase == 0)
				hold_request = 1'b1;

			for (k = 0; k < span; k++) begin
				push_row(random_row(density), phase != 0 && $urandom_range(99) < 4, 1'b0, '0);
				sent++;
				calm = (sent >= 300 && sent < 400);
			end
			phase++;
		end
		calm = 1'b0;

		drain_results();
		repeat (8) @(posedge clk);
		if (failures == 0)
			$display("testbench OK");
		else
			$display("testbench NOT OK");
		$finish;
	end

	// Result side: random back-pressure plus one long hold-off.
	initial begin
		int        hold_left;
		coloring_t want;
		hold_left = 0;
		result_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (result_ch.valid === 1'b1 && result_ch.ready) begin
				if (pending_colorings.size() == 0) begin
					report_mismatch($sformatf("result node %0d with nothing expected",
						result_ch.node_number));
				end else begin
					want = pending_colorings.pop_front();
					if (result_ch.node_number !== want.node)
						report_mismatch($sformatf("node_number %0d, expected %0d",
							result_ch.node_number, want.node));
					if (result_ch.color !== want.color)
						report_mismatch($sformatf("color %0d, expected %0d (node %0d)",
							result_ch.color, want.color, want.node));
					if (result_ch.last !== want.last)
						report_mismatch($sformatf("last %b, expected %b (node %0d)",
							result_ch.last, want.last, want.node));
				end
			end
			if (hold_request) begin
				hold_request = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				result_ch.ready <= 1'b0;
			end else begin
				result_ch.ready <= calm || ($urandom_range(99) >= 14);
			end
		end
	end

	// Ends the run when no transfer of any kind happens for too long.
	initial begin
		int quiet;
		quiet = 0;
		forever begin
			@(posedge clk);
			if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready)
					|| (count_ch.valid && count_ch.ready))
				quiet = 0;
			else
				quiet++;
			if (quiet >= IDLE_LIMIT) begin
				$display("timeout: no transfer for %0d cycles", IDLE_LIMIT);
				$display("testbench NOT OK");
				$finish;
			end
		end
	end

endmodule
